FILE: design/idxhp_pkg.sv
package idxhp_pkg;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_EXTRACT = 3'd1;
    localparam logic [2:0] MODE_REMOVE  = 3'd2;
    localparam logic [2:0] MODE_UPDATE  = 3'd3;
    localparam logic [2:0] MODE_PEEK    = 3'd4;
    localparam logic [2:0] MODE_QUERY   = 3'd5;
    localparam logic [2:0] MODE_FLUSH   = 3'd6;

    // Result status codes.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_ABSENT  = 3'd3;
    localparam logic [2:0] STAT_PRESENT = 3'd4;

    // Number of distinct node ids and heap slots in storage.
    localparam int NODE_SPACE = 256;

    // One heap slot: the node id and its key.
    typedef struct packed {
        logic        [7:0]  node;
        logic signed [31:0] key;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SLOT,
        ST_ENTRY,
        ST_LAST,
        ST_DN_RD,
        ST_DN_L,
        ST_DN_R,
        ST_UP_RD,
        ST_UP_CMP,
        ST_PLACE,
        ST_DONE
    } t_state;

endpackage

FILE: design/indexed_min_heap_queue_core.sv
// A result is registered once the sift walk through the heap memory ends; each level down
// passes ST_DN_RD, ST_DN_L and ST_DN_R, each level up ST_UP_RD and ST_UP_CMP.
// Throughput: one transaction at a time; a new one is taken once the result is registered.
// Reset (i_rst_n low, synchronous) empties the heap and clears every present flag;
// the heap and slot memories need no clearing pass.
module indexed_min_heap_queue_core #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] mode, [10:3] node_id, [42:11] key_in, [47:43] zero
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] node_out, [39:8] key_out, [47:40] slot_out, [56:48] count,
    // [59:57] status, [63:60] zero
    output logic [63:0] o_m_axis_tdata
);

    localparam int EffCap = (CAPACITY < 256) ? CAPACITY : 256;

    idxhp_pkg::t_state r_state, n_state;

    // Storage: heap slots hold node and key, node slot memory maps node to slot.
    idxhp_pkg::t_entry r_heap_mem [idxhp_pkg::NODE_SPACE];
    logic [7:0]        r_slot_mem [idxhp_pkg::NODE_SPACE];
    idxhp_pkg::t_entry r_heap_q;
    logic [7:0]        r_slot_q;
    logic [255:0]      r_present, n_present;

    // Memory port controls.
    logic              h_re, h_we, s_re, s_we;
    logic [7:0]        h_raddr, h_waddr, s_raddr, s_waddr, s_wdata;
    idxhp_pkg::t_entry h_wdata;

    // Transaction and walk registers.
    logic [2:0]         r_mode, n_mode;
    logic [7:0]         r_node, n_node;
    logic signed [31:0] r_key, n_key;
    logic [8:0]         r_cnt, n_cnt;
    logic [7:0]         r_idx, n_idx;
    idxhp_pkg::t_entry  r_cur, n_cur;
    idxhp_pkg::t_entry  r_left, n_left;
    logic               r_has_r, n_has_r;
    logic [7:0]         r_node_o, n_node_o;
    logic signed [31:0] r_key_o, n_key_o;
    logic [7:0]         r_slot_o, n_slot_o;
    logic [2:0]         r_stat, n_stat;
    logic               r_out_valid, n_out_valid;
    logic [63:0]        r_out_data, n_out_data;

    logic       in_acc, out_free;
    logic [9:0] lchild, rchild;
    logic [7:0] parent;
    logic       take_l, take_r;
    logic signed [31:0] best_key;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign lchild   = {1'b0, r_idx, 1'b1};
    assign rchild   = lchild + 10'd1;
    assign parent   = 8'((r_idx - 8'd1) >> 1);

    // Child choice: left on strict less, right only when strictly below the best so far.
    assign take_l   = r_left.key < r_cur.key;
    assign best_key = take_l ? r_left.key : r_cur.key;
    assign take_r   = r_has_r && (r_heap_q.key < best_key);

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_heap_mem[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            r_heap_q <= r_heap_mem[h_raddr];
        end
        if (s_we) begin
            r_slot_mem[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_slot_q <= r_slot_mem[s_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idxhp_pkg::ST_IDLE;
            r_present   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_node     <= n_node;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_has_r    <= n_has_r;
        r_node_o   <= n_node_o;
        r_key_o    <= n_key_o;
        r_slot_o   <= n_slot_o;
        r_stat     <= n_stat;
        r_out_data <= n_out_data;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            idxhp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = idxhp_pkg::ST_DECODE;
                end
            end
            idxhp_pkg::ST_DECODE: begin
                n_state = idxhp_pkg::ST_DONE;
                case (r_mode)
                    idxhp_pkg::MODE_INSERT: begin
                        if (!r_present[r_node] && r_cnt < 9'(EffCap)) begin
                            n_state = idxhp_pkg::ST_UP_RD;
                        end
                    end
                    idxhp_pkg::MODE_EXTRACT, idxhp_pkg::MODE_PEEK: begin
                        if (r_cnt != 9'd0) begin
                            n_state = idxhp_pkg::ST_ENTRY;
                        end
                    end
                    idxhp_pkg::MODE_REMOVE, idxhp_pkg::MODE_UPDATE,
                    idxhp_pkg::MODE_QUERY: begin
                        if (r_present[r_node]) begin
                            n_state = idxhp_pkg::ST_SLOT;
                        end
                    end
                    default: n_state = idxhp_pkg::ST_DONE;
                endcase
            end
            idxhp_pkg::ST_SLOT: begin
                n_state = (r_mode == idxhp_pkg::MODE_UPDATE) ? idxhp_pkg::ST_DN_RD
                                                              : idxhp_pkg::ST_ENTRY;
            end
            idxhp_pkg::ST_ENTRY: begin
                if (r_mode == idxhp_pkg::MODE_EXTRACT || r_mode == idxhp_pkg::MODE_REMOVE) begin
                    n_state = idxhp_pkg::ST_LAST;
                end else begin
                    n_state = idxhp_pkg::ST_DONE;
                end
            end
            idxhp_pkg::ST_LAST: begin
                n_state = ({1'b0, r_idx} < r_cnt) ? idxhp_pkg::ST_DN_RD : idxhp_pkg::ST_DONE;
            end
            idxhp_pkg::ST_DN_RD: begin
                n_state = (lchild < {1'b0, r_cnt}) ? idxhp_pkg::ST_DN_L : idxhp_pkg::ST_UP_RD;
            end
            idxhp_pkg::ST_DN_L: n_state = idxhp_pkg::ST_DN_R;
            idxhp_pkg::ST_DN_R: begin
                n_state = (take_l || take_r) ? idxhp_pkg::ST_DN_RD : idxhp_pkg::ST_UP_RD;
            end
            idxhp_pkg::ST_UP_RD: begin
                n_state = (r_idx == 8'd0) ? idxhp_pkg::ST_PLACE : idxhp_pkg::ST_UP_CMP;
            end
            idxhp_pkg::ST_UP_CMP: begin
                n_state = (r_cur.key < r_heap_q.key) ? idxhp_pkg::ST_UP_RD
                                                     : idxhp_pkg::ST_PLACE;
            end
            idxhp_pkg::ST_PLACE: n_state = idxhp_pkg::ST_DONE;
            idxhp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = idxhp_pkg::ST_IDLE;
                end
            end
            default: n_state = idxhp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_mode      = r_mode;
        n_node      = r_node;
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_left      = r_left;
        n_has_r     = r_has_r;
        n_node_o    = r_node_o;
        n_key_o     = r_key_o;
        n_slot_o    = r_slot_o;
        n_stat      = r_stat;
        n_present   = r_present;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        h_re        = 1'b0;
        h_raddr     = r_idx;
        h_we        = 1'b0;
        h_waddr     = r_idx;
        h_wdata     = r_cur;
        s_re        = 1'b0;
        s_raddr     = r_node;
        s_we        = 1'b0;
        s_waddr     = r_cur.node;
        s_wdata     = r_idx;
        case (r_state)
            idxhp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mode   = i_s_axis_tdata[2:0];
                    n_node   = i_s_axis_tdata[10:3];
                    n_key    = i_s_axis_tdata[42:11];
                    n_node_o = i_s_axis_tdata[10:3];
                    n_key_o  = '0;
                    n_slot_o = '0;
                    n_stat   = idxhp_pkg::STAT_OK;
                end
            end
            idxhp_pkg::ST_DECODE: begin
                case (r_mode)
                    idxhp_pkg::MODE_INSERT: begin
                        if (r_present[r_node]) begin
                            n_stat = idxhp_pkg::STAT_PRESENT;
                        end else if (r_cnt >= 9'(EffCap)) begin
                            n_stat = idxhp_pkg::STAT_FULL;
                        end else begin
                            n_present[r_node] = 1'b1;
                            n_cur   = '{node: r_node, key: r_key};
                            n_idx   = r_cnt[7:0];
                            n_cnt   = r_cnt + 9'd1;
                        end
                    end
                    idxhp_pkg::MODE_EXTRACT, idxhp_pkg::MODE_PEEK: begin
                        if (r_cnt == 9'd0) begin
                            n_stat = idxhp_pkg::STAT_EMPTY;
                        end else begin
                            h_re    = 1'b1;
                            h_raddr = 8'd0;
                            n_idx   = 8'd0;
                        end
                    end
                    idxhp_pkg::MODE_REMOVE, idxhp_pkg::MODE_UPDATE,
                    idxhp_pkg::MODE_QUERY: begin
                        if (!r_present[r_node]) begin
                            n_stat = idxhp_pkg::STAT_ABSENT;
                        end else begin
                            s_re = 1'b1;
                        end
                    end
                    idxhp_pkg::MODE_FLUSH: begin
                        n_cnt     = '0;
                        n_present = '0;
                    end
                    default: n_stat = idxhp_pkg::STAT_OK;
                endcase
            end
            idxhp_pkg::ST_SLOT: begin
                n_idx   = r_slot_q;
                n_cur   = '{node: r_node, key: r_key};
                h_re    = (r_mode != idxhp_pkg::MODE_UPDATE);
                h_raddr = r_slot_q;
            end
            idxhp_pkg::ST_ENTRY: begin
                n_node_o = r_heap_q.node;
                n_key_o  = r_heap_q.key;
                if (r_mode == idxhp_pkg::MODE_QUERY) begin
                    n_slot_o = r_idx;
                end
                if (r_mode == idxhp_pkg::MODE_EXTRACT || r_mode == idxhp_pkg::MODE_REMOVE) begin
                    n_present[r_heap_q.node] = 1'b0;
                    n_cnt   = r_cnt - 9'd1;
                    h_re    = 1'b1;
                    h_raddr = 8'(r_cnt - 9'd1);
                end
            end
            idxhp_pkg::ST_LAST: begin
                n_cur = r_heap_q;
            end
            idxhp_pkg::ST_DN_RD: begin
                h_re    = 1'b1;
                h_raddr = lchild[7:0];
            end
            idxhp_pkg::ST_DN_L: begin
                n_left  = r_heap_q;
                n_has_r = rchild < {1'b0, r_cnt};
                h_re    = 1'b1;
                h_raddr = rchild[7:0];
            end
            idxhp_pkg::ST_DN_R: begin
                // Move the smaller child into the hole.
                if (take_l || take_r) begin
                    h_we    = 1'b1;
                    h_wdata = take_r ? r_heap_q : r_left;
                    s_we    = 1'b1;
                    s_waddr = h_wdata.node;
                    n_idx   = take_r ? rchild[7:0] : lchild[7:0];
                end
            end
            idxhp_pkg::ST_UP_RD: begin
                h_re    = (r_idx != 8'd0);
                h_raddr = parent;
            end
            idxhp_pkg::ST_UP_CMP: begin
                // Pull the larger parent down into the hole.
                if (r_cur.key < r_heap_q.key) begin
                    h_we    = 1'b1;
                    h_wdata = r_heap_q;
                    s_we    = 1'b1;
                    s_waddr = r_heap_q.node;
                    n_idx   = parent;
                end
            end
            idxhp_pkg::ST_PLACE: begin
                h_we = 1'b1;
                s_we = 1'b1;
                if (r_mode == idxhp_pkg::MODE_INSERT || r_mode == idxhp_pkg::MODE_UPDATE) begin
                    n_key_o  = r_cur.key;
                    n_slot_o = r_idx;
                end
            end
            idxhp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_stat, r_cnt, r_slot_o, r_key_o, r_node_o};
                end
            end
            default: n_stat = r_stat;
        endcase
    end

    assign o_s_axis_tready = (r_state == idxhp_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: design/idxhp_checker.sv
module idxhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [47:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);

    // The count never exceeds the node space.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[56:48] <= 9'd256)
        else $error("count out of range");

    // An empty status comes only with an empty heap.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[59:57] == idxhp_pkg::STAT_EMPTY)
        |-> o_m_axis_tdata[56:48] == 9'd0)
        else $error("empty status with entries");

    // A full status comes only with a nonempty heap.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[59:57] == idxhp_pkg::STAT_FULL)
        |-> o_m_axis_tdata[56:48] != 9'd0)
        else $error("full status with no entries");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind indexed_min_heap_queue_core idxhp_checker u_idxhp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
